[src/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cfba_pkg.sv]
// ----------------------------------------------------------------------------
// Free block allocator package
// Shared widths, codes and the node memory request type.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

    localparam int BLK_W         = 10;
    localparam int TOT_W         = 11;
    localparam int BLK_LIMIT     = 1024;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam int BLOCK_COUNT_DEF = 1024;
    localparam int SLOTS_DEF       = 15;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_FIRST_DATA = 1'b0;
    localparam logic REG_TOTAL      = 1'b1;

    localparam logic [9:0]  FIRST_RESET = 10'd9;
    localparam logic [10:0] TOTAL_RESET = 11'd1024;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [BLK_W-1:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

[src/chained_free_block_allocator.sv]
// Allocate and free scan the head node one word a cycle through the single memory port;
// a free that starts a new head then clears its node, as does a free into an empty list.
// Format writes one node word a cycle, chaining the blocks from the first data block to the total.
// One request is worked on at a time; a new one is taken while a result waits.
// Reset clears the list head and loads the registers; the node memory is not cleared.
// ----------------------------------------------------------------------------
// Chained free block allocator
// Grouped free-list allocator of block numbers with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_free_block_allocator #(
    parameter int BLOCK_COUNT = cfba_pkg::BLOCK_COUNT_DEF,
    parameter int SLOTS       = cfba_pkg::SLOTS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [cfba_pkg::PADDR_W-1:0]   paddr,
    input  wire  [cfba_pkg::PDATA_W-1:0]   pwdata,
    output logic [cfba_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_kind,
    input  wire  [cfba_pkg::BLK_W-1:0]     i_block_number,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [cfba_pkg::BLK_W-1:0]     o_granted_block,
    output logic [1:0]                     o_status
);
    import cfba_pkg::*;

    localparam int NODE_WORDS = SLOTS + 1;
    localparam int WW         = $clog2(NODE_WORDS);
    localparam int DEPTH      = BLOCK_COUNT * NODE_WORDS;
    localparam int AW         = $clog2(DEPTH);
    localparam int SW         = $clog2(BLK_LIMIT + NODE_WORDS + 1);
    localparam logic [WW-1:0] LAST_W = WW'(SLOTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FMT   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    function automatic logic in_store(input logic [BLK_W-1:0] b);
        return int'(b) < BLOCK_COUNT;
    endfunction

    t_state           r_state;
    logic [9:0]       r_first;
    logic [TOT_W-1:0] r_total;
    logic [BLK_W-1:0] r_head;
    logic [BLK_W-1:0] r_link;
    logic [BLK_W-1:0] r_cur;
    logic [1:0]       r_kind;
    logic [BLK_W-1:0] r_blk;
    logic [WW-1:0]    r_w;
    logic [WW-1:0]    r_iss;
    logic             r_iss_done;
    logic [WW-1:0]    r_pw;
    logic             r_pv;
    logic [BLK_W-1:0] r_res_grant;
    logic [1:0]       r_res_status;
    logic             r_out_valid;
    logic [BLK_W-1:0] r_out_grant;
    logic [1:0]       r_out_status;

    logic [TOT_W-1:0] w_tot;
    logic [SW-1:0]    w_foff;
    logic [SW-1:0]    w_fsum;
    logic [SW-1:0]    w_fnext;
    logic [BLK_W-1:0] w_fval;
    logic             w_fend;
    logic [BLK_W-1:0] w_node;
    logic [WW-1:0]    w_word;
    logic [AW-1:0]    w_addr;
    t_mem_req         w_req;
    logic [BLK_W-1:0] w_mem_rdata;
    logic [BLK_W-1:0] w_rdata;
    logic             w_is_alloc;
    logic             w_hit;
    logic             w_accept;
    logic             w_cfg_wr;
    logic             w_out_free;

    assign w_tot   = (r_total > TOT_W'(BLK_LIMIT)) ? TOT_W'(BLK_LIMIT) : r_total;
    assign w_foff  = (r_w == '0) ? SW'(NODE_WORDS) : SW'(r_w);
    assign w_fsum  = SW'(r_cur) + w_foff;
    assign w_fnext = SW'(r_cur) + SW'(NODE_WORDS);
    assign w_fval  = (w_fsum >= SW'(w_tot)) ? '0 : w_fsum[BLK_W-1:0];
    assign w_fend  = (w_fnext >= SW'(w_tot));

    assign w_node     = (r_state == S_FMT) ? r_cur : r_head;
    assign w_rdata    = in_store(r_head) ? w_mem_rdata : '0;
    assign w_is_alloc = (r_kind == KIND_ALLOC);
    assign w_hit      = (r_pw != '0) ? (w_is_alloc ? (w_rdata != '0) : (w_rdata == '0))
                                     : w_is_alloc;

    always_comb begin
        w_req  = '0;
        w_word = '0;
        case (r_state)
            S_FMT: begin
                w_req.we    = 1'b1;
                w_word      = r_w;
                w_req.wdata = w_fval;
            end
            S_SCAN: begin
                if (r_pv && w_hit) begin
                    w_req.we    = 1'b1;
                    w_word      = r_pw;
                    w_req.wdata = (!w_is_alloc && r_pw != '0) ? r_blk : '0;
                end else if (!r_pv || r_pw != '0) begin
                    w_req.re = !r_iss_done;
                    w_word   = r_iss;
                end
            end
            S_CLEAR: begin
                w_req.we    = 1'b1;
                w_word      = r_w;
                w_req.wdata = (r_w == '0) ? r_link : '0;
            end
            default: begin
                w_req = '0;
            end
        endcase
        if (!in_store(w_node)) begin
            w_req.we = 1'b0;
            w_req.re = 1'b0;
        end
    end

    assign w_addr = AW'(int'(w_node) * NODE_WORDS + int'(w_word));

    cfba_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .i_addr  (w_addr),
        .o_rdata (w_mem_rdata)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= FIRST_RESET;
            r_total     <= TOTAL_RESET;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_FIRST_DATA: r_first <= pwdata[9:0];
                    REG_TOTAL:      r_total <= pwdata[TOT_W-1:0];
                    default:        r_total <= r_total;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind       <= i_kind;
                        r_blk        <= i_block_number;
                        r_res_grant  <= '0;
                        r_res_status <= ST_OK;
                        r_w          <= '0;
                        r_iss        <= WW'(1);
                        r_iss_done   <= 1'b0;
                        r_pv         <= 1'b0;
                        r_state      <= S_DONE;
                        case (i_kind)
                            KIND_FORMAT: begin
                                if (r_first == '0 || TOT_W'(r_first) >= w_tot) begin
                                    r_head <= '0;
                                end else begin
                                    r_head  <= r_first;
                                    r_cur   <= r_first;
                                    r_state <= S_FMT;
                                end
                            end
                            KIND_ALLOC: begin
                                if (r_head == '0) begin
                                    r_res_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            KIND_FREE: begin
                                if (i_block_number < r_first ||
                                        TOT_W'(i_block_number) >= w_tot) begin
                                    r_res_status <= ST_RANGE;
                                end else if (r_head == '0) begin
                                    r_link  <= '0;
                                    r_head  <= i_block_number;
                                    r_state <= S_CLEAR;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FMT: begin
                    if (r_w == LAST_W) begin
                        r_w <= '0;
                        if (w_fend) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cur <= w_fnext[BLK_W-1:0];
                        end
                    end else begin
                        r_w <= r_w + WW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_pv && r_pw != '0 && w_hit) begin
                        r_res_grant <= w_is_alloc ? w_rdata : '0;
                        r_state     <= S_DONE;
                    end else if (r_pv && r_pw == '0) begin
                        if (w_is_alloc) begin
                            r_head      <= w_rdata;
                            r_res_grant <= r_head;
                            r_state     <= S_DONE;
                        end else begin
                            r_link  <= r_head;
                            r_head  <= r_blk;
                            r_w     <= '0;
                            r_state <= S_CLEAR;
                        end
                    end else begin
                        r_pv <= !r_iss_done;
                        if (!r_iss_done) begin
                            r_pw       <= r_iss;
                            r_iss      <= (r_iss == LAST_W) ? '0 : r_iss + WW'(1);
                            r_iss_done <= (r_iss == '0);
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_w == LAST_W) begin
                        r_state <= S_DONE;
                    end else begin
                        r_w <= r_w + WW'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_grant  <= r_res_grant;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIRST_DATA: prdata = PDATA_W'(r_first);
            REG_TOTAL:      prdata = PDATA_W'(r_total);
            default:        prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_granted_block = r_out_grant;
    assign o_status        = r_out_status;

endmodule

`default_nettype wire

[src/cfba_mem.sv]
// ----------------------------------------------------------------------------
// Node memory
// Single-port synchronous memory of list node words with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_mem #(
    parameter int DEPTH = cfba_pkg::BLOCK_COUNT_DEF * (cfba_pkg::SLOTS_DEF + 1),
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                         i_clk,
    input  cfba_pkg::t_mem_req          i_req,
    input  wire  [AW-1:0]               i_addr,
    output logic [cfba_pkg::BLK_W-1:0]  o_rdata
);
    import cfba_pkg::*;

    logic [BLK_W-1:0] r_mem [DEPTH];
    logic [BLK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/cfba_checker.sv]
// ----------------------------------------------------------------------------
// Free block allocator checker
// Port-level assertions on the result channel and the register port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cfba_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        pready,
    input wire                        o_out_valid,
    input wire                        i_out_stall,
    input wire [cfba_pkg::BLK_W-1:0]  o_granted_block,
    input wire [1:0]                  o_status
);
    import cfba_pkg::*;

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_granted_block) && $stable(o_status))
    `ASSERT_SAME(a_grant_ok, i_clk, i_rst_n, o_out_valid && o_granted_block != '0, o_status == ST_OK)
    `ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_out_valid, o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_RANGE)
    `ASSERT_SAME(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind chained_free_block_allocator cfba_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .pready          (pready),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_granted_block (o_granted_block),
    .o_status        (o_status)
);

`default_nettype wire

[tb/sv/chained_free_block_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Chained free block allocator testbench
// Drives format, allocate, free and unknown-kind requests through the valid/stall input
// channel and checks every result against a behavioural free-list predictor.
// Directed requests cover the empty list, range limits, double frees and the
// register extremes. Random phases then reprogram the registers and mix
// requests with random source gaps and output stalls, plus at most one long hold.
// ----------------------------------------------------------------------------
module chained_free_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfba_pkg::*;

    localparam int BLOCK_COUNT     = BLOCK_COUNT_DEF;
    localparam int SLOTS           = SLOTS_DEF;
    localparam int NODE_WORDS      = SLOTS + 1;
    localparam int RAND_PHASES     = 10;
    localparam int PHASE_REQS      = 145;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_CYCLES = 5000;

    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BLK_W-1:0] blk;
    } alloc_req_t;

    typedef struct packed {
        logic [BLK_W-1:0] granted;
        logic [1:0]       status;
    } grant_t;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               o_in_stall;
    logic [1:0]         in_kind   = '0;
    logic [BLK_W-1:0]   in_blk    = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic [BLK_W-1:0]   o_granted_block;
    logic [1:0]         o_status;

    chained_free_block_allocator #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .SLOTS      (SLOTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (in_kind),
        .i_block_number (in_blk),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_granted_block(o_granted_block),
        .o_status       (o_status)
    );

    // Predictor state: register copies, list head and the node image.
    logic [BLK_W-1:0] fdb_cfg  = FIRST_RESET;
    logic [TOT_W-1:0] tot_cfg  = TOTAL_RESET;
    logic [BLK_W-1:0] head_blk = '0;
    logic [BLK_W-1:0] node_img [0:BLOCK_COUNT*NODE_WORDS-1];

    alloc_req_t req_backlog [$];
    grant_t     grant_due [$];

    logic req_taken = 1'b0;
    logic no_idle   = 1'b0;
    logic hold_done = 1'b0;
    int   src_gap   = 0;
    int   snk_gap   = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   sent_cnt  = 0;
    int   taken_cnt = 0;
    int   checked_cnt = 0;
    int   fail_cnt  = 0;
    int   kind_cnt [4] = '{default: 0};
    int   stat_cnt [4] = '{default: 0};

    function automatic int dev_limit();
        return (tot_cfg > TOT_W'(BLK_LIMIT)) ? BLK_LIMIT : int'(tot_cfg);
    endfunction

    function automatic logic [BLK_W-1:0] node_peek(int blk, int w);
        if (blk >= BLOCK_COUNT) begin
            return '0;
        end
        return node_img[blk*NODE_WORDS + w];
    endfunction

    function automatic void node_poke(int blk, int w, int v);
        if (blk < BLOCK_COUNT) begin
            node_img[blk*NODE_WORDS + w] = v[BLK_W-1:0];
        end
    endfunction

    function automatic void clear_node(int blk);
        int w;
        for (w = 0; w < NODE_WORDS; w++) begin
            node_poke(blk, w, 0);
        end
    endfunction

    function automatic void chain_blocks();
        int lim;
        int nxt;
        int cur;
        int w;
        lim = dev_limit();
        nxt = int'(fdb_cfg);
        if (nxt == 0 || nxt >= lim) begin
            head_blk = '0;
            return;
        end
        head_blk = fdb_cfg;
        do begin
            cur = nxt;
            for (w = 1; w <= SLOTS; w++) begin
                nxt++;
                node_poke(cur, w, (nxt >= lim) ? 0 : nxt);
            end
            nxt++;
            node_poke(cur, 0, (nxt >= lim) ? 0 : nxt);
        end while (nxt < lim);
    endfunction

    function automatic grant_t predict_grant(alloc_req_t rq);
        grant_t           g;
        int               slot;
        logic [BLK_W-1:0] v;
        logic             placed;
        g.granted = '0;
        g.status  = ST_OK;
        case (rq.kind)
            KIND_FORMAT: begin
                chain_blocks();
            end
            KIND_ALLOC: begin
                if (head_blk == 0) begin
                    g.status = ST_EMPTY;
                end else begin
                    for (slot = 1; slot <= SLOTS && g.granted == 0; slot++) begin
                        v = node_peek(int'(head_blk), slot);
                        if (v != 0) begin
                            g.granted = v;
                            node_poke(int'(head_blk), slot, 0);
                        end
                    end
                    if (g.granted == 0) begin
                        g.granted = head_blk;
                        head_blk  = node_peek(int'(g.granted), 0);
                        node_poke(int'(g.granted), 0, 0);
                    end
                end
            end
            KIND_FREE: begin
                if (rq.blk < fdb_cfg || int'(rq.blk) >= dev_limit()) begin
                    g.status = ST_RANGE;
                end else if (head_blk == 0) begin
                    clear_node(int'(rq.blk));
                    head_blk = rq.blk;
                end else begin
                    placed = 1'b0;
                    for (slot = 1; slot <= SLOTS && !placed; slot++) begin
                        if (node_peek(int'(head_blk), slot) == 0) begin
                            node_poke(int'(head_blk), slot, int'(rq.blk));
                            placed = 1'b1;
                        end
                    end
                    if (!placed) begin
                        clear_node(int'(rq.blk));
                        node_poke(int'(rq.blk), 0, int'(head_blk));
                        head_blk = rq.blk;
                    end
                end
            end
            default: begin
            end
        endcase
        return g;
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Request driver: a new request may be presented once the current one is taken.
    always @(negedge i_clk) begin : drv
        alloc_req_t nx;
        if (i_rst_n && (!in_valid || req_taken)) begin
            if (src_gap != 0) begin
                in_valid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (req_backlog.size() != 0) begin
                nx = req_backlog.pop_front();
                in_valid <= 1'b1;
                in_kind  <= nx.kind;
                in_blk   <= nx.blk;
                if (!no_idle && $urandom_range(0, 5) == 0) begin
                    src_gap <= $urandom_range(1, 4);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result sink: short random stalls and at most one long hold while requests keep coming.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_cnt >= 500 && sent_cnt - taken_cnt >= 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (snk_gap != 0) begin
            out_stall <= 1'b1;
            snk_gap   <= snk_gap - 1;
        end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            out_stall <= 1'b1;
            snk_gap   <= $urandom_range(0, 3);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : mon
        grant_t     want;
        alloc_req_t rq;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                checked_cnt++;
                if (grant_due.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result granted_block=%0d status=%0d",
                             $time, o_granted_block, o_status);
                end else begin
                    want = grant_due.pop_front();
                    stat_cnt[want.status]++;
                    if (o_granted_block !== want.granted) begin
                        fail_cnt++;
                        $display("%0t: granted_block expected %0d, got %0d",
                                 $time, want.granted, o_granted_block);
                    end
                    if (o_status !== want.status) begin
                        fail_cnt++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_status);
                    end
                end
            end
            if (in_valid && !o_in_stall) begin
                rq.kind = in_kind;
                rq.blk  = in_blk;
                grant_due.push_back(predict_grant(rq));
                kind_cnt[rq.kind]++;
                taken_cnt++;
            end
        end
        req_taken <= i_rst_n && in_valid && !o_in_stall;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_req(logic [1:0] kind, int blk);
        alloc_req_t rq;
        rq.kind = kind;
        rq.blk  = blk[BLK_W-1:0];
        req_backlog.push_back(rq);
        sent_cnt++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (taken_cnt != sent_cnt || grant_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [PDATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_FIRST_DATA) begin
            fdb_cfg = val[BLK_W-1:0];
        end else begin
            tot_cfg = val[TOT_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int fdb, int tot);
        wait_idle();
        reg_write(REG_FIRST_DATA, PDATA_W'(fdb));
        reg_write(REG_TOTAL, PDATA_W'(tot));
        @(posedge i_clk);
    endtask

    task automatic run_phase(int fdb, int tot, int n);
        int lim;
        int alloc_pct;
        int pick;
        int b;
        int i;
        set_config(fdb, tot);
        lim       = (tot[TOT_W-1:0] > BLK_LIMIT) ? BLK_LIMIT : int'(tot[TOT_W-1:0]);
        fdb       = int'(fdb[BLK_W-1:0]);
        alloc_pct = $urandom_range(25, 70);
        queue_req(KIND_FORMAT, $urandom_range(0, 1023));
        for (i = 1; i < n; i++) begin
            pick = $urandom_range(0, 99);
            b    = $urandom_range(0, 1023);
            if (pick < 2) begin
                queue_req(KIND_NONE, b);
            end else if (pick < 5) begin
                queue_req(KIND_FORMAT, b);
            end else if (pick < 5 + alloc_pct) begin
                queue_req(KIND_ALLOC, b);
            end else begin
                if (fdb < lim && $urandom_range(0, 9) != 0) begin
                    b = $urandom_range(fdb, lim - 1);
                end
                queue_req(KIND_FREE, b);
            end
        end
    endtask

    initial begin : stim
        int i;
        int ph;
        int f;
        int t;
        for (i = 0; i < BLOCK_COUNT*NODE_WORDS; i++) begin
            node_img[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: the empty list and the range limits.
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 1023);
        queue_req(KIND_FREE, 0);
        queue_req(KIND_FREE, 8);
        queue_req(KIND_NONE, 1023);
        queue_req(KIND_ALLOC, 1023);
        queue_req(KIND_ALLOC, 0);

        // Widest chain; a total above the block limit acts as the block limit.
        set_config(1, 2047);
        queue_req(KIND_FORMAT, 1023);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 1);
        queue_req(KIND_FREE, 1023);
        queue_req(KIND_ALLOC, 1023);

        // A one-block chain, then a double free of the same block.
        set_config(1023, 1024);
        queue_req(KIND_FORMAT, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 1023);
        queue_req(KIND_FREE, 1022);
        queue_req(KIND_FREE, 1023);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_ALLOC, 0);

        // A zero first data block leaves the formatted list empty.
        set_config(0, 2);
        queue_req(KIND_FORMAT, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 0);
        queue_req(KIND_FREE, 1);
        queue_req(KIND_ALLOC, 0);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: begin
                    f = $urandom_range(1, 24);
                    t = $urandom_range(1000, 1024);
                end
                1, 2, 3: begin
                    f = $urandom_range(1, 1000);
                    t = f + $urandom_range(2, 90);
                end
                4: begin
                    f = $urandom_range(0, 1023);
                    t = $urandom_range(2, 2047);
                end
                default: begin
                    f = $urandom_range(900, 1023);
                    t = $urandom_range(1025, 2047);
                end
            endcase
            if (ph == RAND_PHASES - 1) begin
                no_idle <= 1'b1;
            end
            run_phase(f, t, PHASE_REQS);
        end

        wait_idle();
        repeat (40) @(negedge i_clk);

        $display("Requests: %0d format, %0d allocate, %0d free, %0d unknown kind; %0d results",
                 kind_cnt[KIND_FORMAT], kind_cnt[KIND_ALLOC], kind_cnt[KIND_FREE],
                 kind_cnt[KIND_NONE], checked_cnt);
        $display("Statuses: %0d ok, %0d list empty, %0d out of range; long output hold %s",
                 stat_cnt[ST_OK], stat_cnt[ST_EMPTY], stat_cnt[ST_RANGE],
                 hold_done ? "applied" : "not applied");
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
